// ===== src/btbb_pkg.sv =====
// Shared constants, types and controller states for the bloom threshold box blur.
// No dependencies; every other file imports this package.
package btbb_pkg;

  localparam int unsigned MaxRadius = 7;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned WinRows   = 2 * MaxRadius + 1;
  localparam int unsigned RingDepth = WinRows * (MaxWidth + 1);

  localparam int unsigned AW    = $clog2(RingDepth);
  localparam int unsigned RW    = $clog2(MaxRadius + 1);
  localparam int unsigned DW    = RW + 2;
  localparam int unsigned WW    = $clog2(MaxWidth + 1);
  localparam int unsigned HW    = $clog2(MaxHeight + 1);
  localparam int unsigned COLW  = $clog2(MaxWidth);
  localparam int unsigned ROWW  = $clog2(MaxHeight);
  localparam int unsigned LINW  = ROWW + WW + 1;
  localparam int unsigned SUMW  = $clog2(WinRows * WinRows * 65536);
  localparam int unsigned CH    = 16;
  localparam int unsigned PXW   = 3 * CH;
  localparam int unsigned CFG_IW = 3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] RegEnable    = 3'd0;
  localparam logic [CFG_IW-1:0] RegThreshold = 3'd1;
  localparam logic [CFG_IW-1:0] RegRadius    = 3'd2;
  localparam logic [CFG_IW-1:0] RegRecip     = 3'd3;
  localparam logic [CFG_IW-1:0] RegWidth     = 3'd4;
  localparam logic [CFG_IW-1:0] RegHeight    = 3'd5;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STORE, ST_MUL, ST_CHECK, ST_ORIG_RD, ST_ORIG_CAP,
    ST_RD, ST_SQ, ST_ACC, ST_SCALE, ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic store;
    logic mul;
    logic orig_rd;
    logic orig_cap;
    logic rd;
    logic sq;
    logic acc;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic item_ready;
    logic win_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/btbb_if.sv =====
// Channel interfaces: pixel input, result output and configuration write.
// Depends on btbb_pkg.
interface btbb_in_if;
  import btbb_pkg::*;
  logic          valid;
  logic          ready;
  logic          cmd;
  logic [CH-1:0] in_red;
  logic [CH-1:0] in_green;
  logic [CH-1:0] in_blue;
  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface btbb_out_if;
  import btbb_pkg::*;
  logic          valid;
  logic          ready;
  logic [CH-1:0] out_red;
  logic [CH-1:0] out_green;
  logic [CH-1:0] out_blue;
  logic          frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface btbb_cfg_if;
  import btbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CH-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/btbb_ctrl.sv =====
// Controller state machine: sequences store, readiness check, window walk and emit.
// Depends on btbb_pkg.
module btbb_ctrl import btbb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_cmd_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = (in_cmd_i == CmdPixel) ? ST_STORE : ST_MUL;
      end
      ST_STORE:    state_d = ST_MUL;
      ST_MUL:      state_d = ST_CHECK;
      ST_CHECK:    state_d = status_i.item_ready ? ST_ORIG_RD : ST_IDLE;
      ST_ORIG_RD:  state_d = ST_ORIG_CAP;
      ST_ORIG_CAP: state_d = ST_RD;
      ST_RD:       state_d = ST_SQ;
      ST_SQ:       state_d = ST_ACC;
      ST_ACC:      state_d = status_i.win_last ? ST_SCALE : ST_RD;
      ST_SCALE:    state_d = ST_EMIT;
      ST_EMIT:     if (status_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_STORE:    cmd_o.store    = 1'b1;
      ST_MUL:      cmd_o.mul      = 1'b1;
      ST_ORIG_RD:  cmd_o.orig_rd  = 1'b1;
      ST_ORIG_CAP: cmd_o.orig_cap = 1'b1;
      ST_RD:       cmd_o.rd       = 1'b1;
      ST_SQ:       cmd_o.sq       = 1'b1;
      ST_ACC:      cmd_o.acc      = 1'b1;
      ST_SCALE:    cmd_o.scale    = 1'b1;
      ST_EMIT:     cmd_o.emit     = status_i.out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/btbb_dp.sv =====
// Datapath: config registers, pixel ring memory, counters, window accumulator, output register.
// Depends on btbb_pkg and the channel interfaces.
module btbb_dp import btbb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  btbb_in_if.sink  in_i,
  btbb_out_if.source out_o,
  btbb_cfg_if.sink cfg_i,
  input  cmd_t    cmd_i,
  output status_t status_o
);

  // configuration registers
  logic          enable_q;
  logic [CH-1:0] thresh_q, recip_q;
  logic [2:0]    radius_q;
  logic [10:0]   fwidth_q;
  logic [12:0]   fheight_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      thresh_q  <= 16'd3891;
      radius_q  <= 3'd3;
      recip_q   <= 16'd1337;
      fwidth_q  <= 11'd1024;
      fheight_q <= 13'd768;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegEnable:    enable_q  <= cfg_i.data[0];
        RegThreshold: thresh_q  <= cfg_i.data;
        RegRadius:    radius_q  <= cfg_i.data[2:0];
        RegRecip:     recip_q   <= cfg_i.data;
        RegWidth:     fwidth_q  <= cfg_i.data[10:0];
        RegHeight:    fheight_q <= cfg_i.data[12:0];
        default:      ;
      endcase
    end
  end

  // effective sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  always_comb begin
    if (fwidth_q == '0) w_eff = WW'(1);
    else if (32'(fwidth_q) > MaxWidth) w_eff = WW'(MaxWidth);
    else w_eff = WW'(fwidth_q);
    if (fheight_q == '0) h_eff = HW'(1);
    else if (32'(fheight_q) > MaxHeight) h_eff = HW'(MaxHeight);
    else h_eff = HW'(fheight_q);
    if (32'(radius_q) > MaxRadius) r_eff = RW'(MaxRadius);
    else r_eff = RW'(radius_q);
  end

  // latched input pixel
  logic [PXW-1:0] px_in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      px_in_q <= {in_i.in_blue, in_i.in_green, in_i.in_red};
    end
  end

  // counters and ring slots
  logic [COLW-1:0] in_col_q, out_col_q;
  logic [ROWW-1:0] in_row_q, out_row_q;
  logic [AW-1:0]   wr_slot_q, rd_slot_q;
  logic            in_ahead_q;
  logic [WW-1:0]   in_col_inc, out_col_inc;
  logic [HW-1:0]   in_row_inc, out_row_inc;
  logic [HW-1:0]   in_row_nxt, out_row_nxt;

  assign in_col_inc  = WW'(in_col_q) + WW'(1);
  assign out_col_inc = WW'(out_col_q) + WW'(1);
  assign in_row_inc  = HW'(in_row_q) + HW'(1);
  assign out_row_inc = HW'(out_row_q) + HW'(1);
  assign in_row_nxt  = (in_col_inc >= w_eff) ? in_row_inc : HW'(in_row_q);
  assign out_row_nxt = (out_col_inc >= w_eff) ? out_row_inc : HW'(out_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      wr_slot_q  <= '0;
      rd_slot_q  <= '0;
      in_ahead_q <= 1'b0;
    end else begin
      // advance input position on a stored pixel
      if (cmd_i.store) begin
        wr_slot_q <= (32'(wr_slot_q) == RingDepth - 1) ? '0 : wr_slot_q + AW'(1);
        in_col_q  <= (in_col_inc >= w_eff) ? '0 : in_col_inc[COLW-1:0];
        if (in_row_nxt >= h_eff) begin
          in_row_q   <= '0;
          in_ahead_q <= 1'b1;
        end else begin
          in_row_q <= in_row_nxt[ROWW-1:0];
        end
      end
      // advance output position on an emitted result
      if (cmd_i.emit) begin
        rd_slot_q <= (32'(rd_slot_q) == RingDepth - 1) ? '0 : rd_slot_q + AW'(1);
        out_col_q <= (out_col_inc >= w_eff) ? '0 : out_col_inc[COLW-1:0];
        if (out_row_nxt >= h_eff) begin
          out_row_q  <= '0;
          in_ahead_q <= 1'b0;
        end else begin
          out_row_q <= out_row_nxt[ROWW-1:0];
        end
      end
    end
  end

  // readiness check: linear input position against last window pixel
  logic [HW-1:0]   ny;
  logic [WW-1:0]   nx;
  logic [LINW-1:0] in_lin_q, need_lin_q;
  always_comb begin
    ny = HW'(out_row_q) + HW'(r_eff);
    if (ny > h_eff - HW'(1)) ny = h_eff - HW'(1);
    nx = WW'(out_col_q) + WW'(r_eff);
    if (nx > w_eff - WW'(1)) nx = w_eff - WW'(1);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      in_lin_q   <= LINW'(in_row_q) * LINW'(w_eff) + LINW'(in_col_q);
      need_lin_q <= LINW'(ny) * LINW'(w_eff) + LINW'(nx);
    end
  end
  assign status_o.item_ready = in_ahead_q || (in_lin_q > need_lin_q);

  // window walk registers
  logic signed [DW-1:0] dy_q, dx_q, r_pos, r_neg;
  logic [AW-1:0]        rb_q;
  logic [AW:0]          rw_prod, rb_init, rb_next;
  logic signed [AW+2:0] addr_t;
  logic [AW-1:0]        win_addr, raddr;

  assign r_pos   = DW'(r_eff);
  assign r_neg   = -r_pos;
  assign rw_prod = (AW+1)'(r_eff) * (AW+1)'(w_eff);
  assign rb_init = ({1'b0, rd_slot_q} >= rw_prod) ? ({1'b0, rd_slot_q} - rw_prod)
                 : ({1'b0, rd_slot_q} + (AW+1)'(RingDepth) - rw_prod);
  always_comb begin
    rb_next = {1'b0, rb_q} + (AW+1)'(w_eff);
    if (32'(rb_next) >= RingDepth) rb_next = rb_next - (AW+1)'(RingDepth);
    addr_t = (AW+3)'(rb_q) + (AW+3)'(RingDepth) + (AW+3)'(dx_q);
    if (addr_t >= (AW+3)'(RingDepth)) addr_t = addr_t - (AW+3)'(RingDepth);
    win_addr = addr_t[AW-1:0];
  end

  assign status_o.win_last = (dx_q == r_pos) && (dy_q == r_pos);

  always_ff @(posedge clk_i) begin
    if (cmd_i.orig_rd) begin
      dy_q <= r_neg;
      dx_q <= r_neg;
      rb_q <= rb_init[AW-1:0];
    end else if (cmd_i.acc) begin
      if (dx_q == r_pos) begin
        dx_q <= r_neg;
        dy_q <= dy_q + DW'(1);
        rb_q <= rb_next[AW-1:0];
      end else begin
        dx_q <= dx_q + DW'(1);
      end
    end
  end

  // ring memory
  logic [PXW-1:0] ring_mem [RingDepth];
  logic [PXW-1:0] rdata_q;
  assign raddr = cmd_i.orig_rd ? rd_slot_q : win_addr;
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) ring_mem[wr_slot_q] <= px_in_q;
    rdata_q <= ring_mem[raddr];
  end

  // in-frame test for the current neighbor
  logic signed [ROWW+1:0] yy;
  logic signed [COLW+1:0] xx;
  logic                   inwin_q;
  assign yy = (ROWW+2)'(out_row_q) + (ROWW+2)'(dy_q);
  assign xx = (COLW+2)'(out_col_q) + (COLW+2)'(dx_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      inwin_q <= (yy >= 0) && (yy < $signed((ROWW+2)'(h_eff))) &&
                 (xx >= 0) && (xx < $signed((COLW+2)'(w_eff)));
    end
  end

  // squares of the neighbor and threshold
  logic [PXW-1:0]  orig_q, npx_q;
  logic [2*CH-1:0] sqr_q, sqg_q, sqb_q, tsq_q;
  logic            inw2_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.orig_cap) orig_q <= rdata_q;
    if (cmd_i.sq) begin
      npx_q  <= rdata_q;
      inw2_q <= inwin_q;
      sqr_q  <= rdata_q[CH-1:0] * rdata_q[CH-1:0];
      sqg_q  <= rdata_q[2*CH-1:CH] * rdata_q[2*CH-1:CH];
      sqb_q  <= rdata_q[3*CH-1:2*CH] * rdata_q[3*CH-1:2*CH];
      tsq_q  <= thresh_q * thresh_q;
    end
  end

  // accumulate bright neighbors
  logic [SUMW-1:0] sr_q, sg_q, sb_q;
  logic [2*CH+1:0] sqsum;
  logic            bright;
  assign sqsum  = (2*CH+2)'(sqr_q) + (2*CH+2)'(sqg_q) + (2*CH+2)'(sqb_q);
  assign bright = inw2_q && (sqsum >= (2*CH+2)'(tsq_q));
  always_ff @(posedge clk_i) begin
    if (cmd_i.orig_rd) begin
      sr_q <= '0;
      sg_q <= '0;
      sb_q <= '0;
    end else if (cmd_i.acc && bright) begin
      sr_q <= sr_q + SUMW'(npx_q[CH-1:0]);
      sg_q <= sg_q + SUMW'(npx_q[2*CH-1:CH]);
      sb_q <= sb_q + SUMW'(npx_q[3*CH-1:2*CH]);
    end
  end

  // scale by reciprocal
  logic [SUMW+CH-1:0] pr_q, pg_q, pb_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      pr_q <= (SUMW+CH)'(sr_q) * (SUMW+CH)'(recip_q);
      pg_q <= (SUMW+CH)'(sg_q) * (SUMW+CH)'(recip_q);
      pb_q <= (SUMW+CH)'(sb_q) * (SUMW+CH)'(recip_q);
    end
  end

  function automatic logic [CH-1:0] add_sat(input logic [CH-1:0] o,
                                            input logic [SUMW+CH-1:0] p);
    logic [SUMW+CH:0] rnd;
    logic [SUMW+1:0]  v;
    rnd = (SUMW+CH+1)'(p) + (SUMW+CH+1)'(32768);
    v   = (SUMW+2)'(o) + (SUMW+2)'(rnd[SUMW+CH:CH]);
    return (v > (SUMW+2)'(16'hFFFF)) ? 16'hFFFF : v[CH-1:0];
  endfunction

  // output register
  logic          ovalid_q;
  logic [CH-1:0] ored_q, ogreen_q, oblue_q;
  logic          olast_q;
  assign status_o.out_free = !ovalid_q || out_o.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (enable_q) begin
        ored_q   <= add_sat(orig_q[CH-1:0], pr_q);
        ogreen_q <= add_sat(orig_q[2*CH-1:CH], pg_q);
        oblue_q  <= add_sat(orig_q[3*CH-1:2*CH], pb_q);
      end else begin
        ored_q   <= orig_q[CH-1:0];
        ogreen_q <= orig_q[2*CH-1:CH];
        oblue_q  <= orig_q[3*CH-1:2*CH];
      end
      olast_q <= (HW'(out_row_q) == h_eff - HW'(1)) && (WW'(out_col_q) == w_eff - WW'(1));
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_red    = ored_q;
  assign out_o.out_green  = ogreen_q;
  assign out_o.out_blue   = oblue_q;
  assign out_o.frame_last = olast_q;

endmodule

// ===== src/bloom_threshold_box_blur_top.sv =====
// Top level of the bloom threshold box blur: controller plus datapath.
// Depends on btbb_pkg, btbb_if, btbb_ctrl and btbb_dp.

// Bloom over a raster RGB stream in Q4.12, one item at a time. An item is
// taken in the idle cycle; a pixel is then stored (STORE), and its input
// position is compared against the window of the next pending result
// (MUL, CHECK); a drain skips STORE. An item that releases nothing then
// returns to idle. An item that releases a result fetches the original
// pixel (ORIG_RD, ORIG_CAP), walks the full (2R+1)^2 window through the
// single read port of the pixel ring with RD, SQ and ACC for each neighbor,
// then scales and emits (SCALE, EMIT), waiting in EMIT while the receiver
// holds the output register. Results trail the input by R rows plus R
// pixels; drain items (cmd=1) flush the rest at frame end. The user must
// write configuration only while no item is in flight; the block itself
// does not enforce it.
module bloom_threshold_box_blur_top import btbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  btbb_in_if.sink     in_i,
  btbb_out_if.source  out_o,
  btbb_cfg_if.sink    cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  btbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  btbb_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

// ===== test/btbb_checker.sv =====
// Scoreboard for the bloom threshold box blur: snoops the three channels,
// predicts every result from the accepted pixels and compares in order.
// Depends on btbb_pkg and btbb_if.
module btbb_checker import btbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  btbb_in_if          in_i,
  btbb_out_if         out_i,
  btbb_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned waiting_o,
  output int unsigned unflushed_o,
  output int unsigned matched_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH-1:0] red;
    logic [CH-1:0] green;
    logic [CH-1:0] blue;
    logic          last;
  } bloom_px_t;

  bloom_px_t awaited_q[$];

  logic [PXW-1:0] pixel_ring [RingDepth];
  int unsigned col_in, row_in, col_out, row_out;
  int unsigned slot_wr, slot_rd;
  bit          input_ahead;
  int unsigned pixels_taken, results_made;

  // shadow of the register file
  logic          en_q;
  logic [CH-1:0] thr_q;
  logic [2:0]    rad_q;
  logic [CH-1:0] rcp_q;
  logic [10:0]   width_q;
  logic [12:0]   height_q;

  function automatic logic [CH-1:0] chan(logic [PXW-1:0] px, int k);
    return px[CH*k +: CH];
  endfunction

  function automatic bit is_bright(logic [PXW-1:0] px);
    bit [35:0] energy;
    bit [35:0] limit;
    energy = 36'(chan(px, 0)) * chan(px, 0) + 36'(chan(px, 1)) * chan(px, 1)
           + 36'(chan(px, 2)) * chan(px, 2);
    limit  = 36'(thr_q) * thr_q;
    return energy >= limit;
  endfunction

  function automatic logic [CH-1:0] glow_add(logic [CH-1:0] orig, bit [31:0] sum);
    bit [63:0] v;
    v = 64'(orig) + ((64'(sum) * rcp_q + 64'd32768) >> 16);
    return (v > 64'hFFFF) ? 16'hFFFF : v[CH-1:0];
  endfunction

  // Advance the raster counters for one accepted item and queue any result it releases.
  task automatic predict_bloom(logic cmd, logic [PXW-1:0] px);
    int unsigned w, h, r, ny, nx;
    int          dy, dx, yy, xx, pos;
    bit [31:0]   sr, sg, sb;
    logic [PXW-1:0] orig, nb;
    bloom_px_t   res;
    w = (width_q < 1) ? 1 : (width_q > MaxWidth) ? MaxWidth : width_q;
    h = (height_q < 1) ? 1 : (height_q > MaxHeight) ? MaxHeight : height_q;
    r = (rad_q > MaxRadius) ? MaxRadius : rad_q;
    if (cmd == CmdPixel) begin
      pixel_ring[slot_wr] = px;
      slot_wr = (slot_wr + 1) % RingDepth;
      pixels_taken++;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (row_in >= h) begin
        row_in = 0;
        input_ahead = 1;
      end
    end
    ny = (row_out + r > h - 1) ? h - 1 : row_out + r;
    nx = (col_out + r > w - 1) ? w - 1 : col_out + r;
    if (!input_ahead &&
        !(longint'(row_in) * w + col_in > longint'(ny) * w + nx)) return;
    orig = pixel_ring[slot_rd];
    sr = 0;
    sg = 0;
    sb = 0;
    for (dy = -int'(r); dy <= int'(r); dy++) begin
      yy = int'(row_out) + dy;
      if (yy < 0 || yy >= int'(h)) continue;
      for (dx = -int'(r); dx <= int'(r); dx++) begin
        xx = int'(col_out) + dx;
        if (xx < 0 || xx >= int'(w)) continue;
        pos = (int'(slot_rd) + int'(RingDepth) + dy * int'(w) + dx) % int'(RingDepth);
        nb = pixel_ring[pos];
        if (is_bright(nb)) begin
          sr += chan(nb, 0);
          sg += chan(nb, 1);
          sb += chan(nb, 2);
        end
      end
    end
    if (en_q) begin
      res.red   = glow_add(chan(orig, 0), sr);
      res.green = glow_add(chan(orig, 1), sg);
      res.blue  = glow_add(chan(orig, 2), sb);
    end else begin
      res.red   = chan(orig, 0);
      res.green = chan(orig, 1);
      res.blue  = chan(orig, 2);
    end
    res.last = (row_out == h - 1) && (col_out == w - 1);
    awaited_q = {awaited_q, res};
    results_made++;
    slot_rd = (slot_rd + 1) % RingDepth;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (row_out >= h) begin
      row_out = 0;
      input_ahead = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bloom_px_t exp_px;
    bloom_px_t got_px;
    if (!rst_ni) begin
      foreach (pixel_ring[i]) pixel_ring[i] = '0;
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      slot_wr = 0; slot_rd = 0; input_ahead = 0;
      pixels_taken = 0; results_made = 0;
      en_q = 1'b0; thr_q = 16'd3891; rad_q = 3'd3; rcp_q = 16'd1337;
      width_q = 11'd1024; height_q = 13'd768;
      awaited_q.delete();
      fail_count_o = 0;
      matched_o = 0;
    end else begin
      // register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegEnable:    en_q     = cfg_i.data[0];
          RegThreshold: thr_q    = cfg_i.data;
          RegRadius:    rad_q    = cfg_i.data[2:0];
          RegRecip:     rcp_q    = cfg_i.data;
          RegWidth:     width_q  = cfg_i.data[10:0];
          RegHeight:    height_q = cfg_i.data[12:0];
          default: ;
        endcase
      end
      // compare result transfers against the oldest prediction
      if (out_i.valid && out_i.ready) begin
        got_px = {out_i.out_red, out_i.out_green, out_i.out_blue, out_i.frame_last};
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t checker: result with nothing pending: %h", $realtime, got_px);
        end else begin
          exp_px = awaited_q.pop_front();
          if (got_px !== exp_px) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t checker: mismatch exp r=%h g=%h b=%h last=%b",
                        " got r=%h g=%h b=%h last=%b"},
                       $realtime, exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                       got_px.red, got_px.green, got_px.blue, got_px.last);
          end else begin
            matched_o++;
          end
        end
      end
      // predict from input transfers
      if (in_i.valid && in_i.ready)
        predict_bloom(in_i.cmd, {in_i.in_blue, in_i.in_green, in_i.in_red});
    end
    waiting_o   = awaited_q.size();
    unflushed_o = pixels_taken - results_made;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the bloom threshold box blur: clock, reset, stimulus
// and verdict. Depends on btbb_pkg, btbb_if, the RTL top and btbb_checker.
module tb;
  import btbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  btbb_in_if  in_ch ();
  btbb_out_if out_ch ();
  btbb_cfg_if cfg_ch ();

  int unsigned fail_count, waiting, unflushed, matched;
  int unsigned pixel_sent, drain_sent, settings_run, items_sent;
  int unsigned cur_w, cur_h, cur_r;
  logic [CH-1:0] cur_thr;

  bloom_threshold_box_blur_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  btbb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .cfg_i       (cfg_ch),
    .fail_count_o(fail_count),
    .waiting_o   (waiting),
    .unflushed_o (unflushed),
    .matched_o   (matched)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offer one item and hold it until the transfer; leaves valid high.
  task automatic send_item(logic cmd, logic [PXW-1:0] px);
    bit calm;
    calm = (items_sent >= 300 && items_sent < 450);
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.in_red   <= px[15:0];
    in_ch.in_green <= px[31:16];
    in_ch.in_blue  <= px[47:32];
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (cmd == CmdPixel) pixel_sent++;
    else drain_sent++;
  endtask

  // Push out what is left with drains, then wait for every result and for
  // the window walk to finish so the block is idle.
  task automatic flush_all();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (unflushed > 0) begin
      @(posedge clk_i);
      send_item(CmdDrain, 48'({$urandom, $urandom}));
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    do @(posedge clk_i); while (waiting != 0);
    repeat (3 * (2 * cur_r + 1) * (2 * cur_r + 1) + 30) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CH-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Write all six registers and track the effective frame geometry.
  task automatic set_config(logic en, logic [CH-1:0] thr, logic [2:0] rad,
                            logic [CH-1:0] rcp, logic [10:0] w, logic [12:0] h);
    cfg_write(RegEnable, {15'd0, en});
    cfg_write(RegThreshold, thr);
    cfg_write(RegRadius, {13'd0, rad});
    cfg_write(RegRecip, rcp);
    cfg_write(RegWidth, {5'd0, w});
    cfg_write(RegHeight, {3'd0, h});
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    cur_w   = (w < 1) ? 1 : (w > MaxWidth) ? MaxWidth : w;
    cur_h   = (h < 1) ? 1 : (h > MaxHeight) ? MaxHeight : h;
    cur_r   = rad;
    cur_thr = thr;
    settings_run++;
  endtask

  function automatic logic [PXW-1:0] pick_pixel();
    logic [CH-1:0] near;
    near = 16'(cur_thr / 2 + $urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {PXW{1'b1}};
      2: return 48'({$urandom, $urandom});
      3: return {near, near, near};
      4: return {3'd0, 13'($urandom), 3'd0, 13'($urandom), 3'd0, 13'($urandom)};
      default: return 48'($urandom) << (16 * $urandom_range(0, 2));
    endcase
  endfunction

  // Random frame; stray drains mixed in as noise.
  task automatic random_frame();
    for (int unsigned i = 0; i < cur_w * cur_h; i++) begin
      if ($urandom_range(99) < 5) send_item(CmdDrain, 48'({$urandom, $urandom}));
      send_item(CmdPixel, pick_pixel());
    end
  endtask

  // Receiver: random stalls, one long hold-off, one stretch without stalls.
  initial begin
    int unsigned cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 6000) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        cyc += 3000;
      end
      if (cyc >= 40000 && cyc < 90000) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 19);
    end
  end

  // Guard against a hang.
  initial begin
    #100ms;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    logic [2:0]    rad;
    logic [10:0]   w;
    logic [12:0]   h;
    logic [CH-1:0] thr, rcp;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdPixel;
    in_ch.in_red = '0;
    in_ch.in_green = '0;
    in_ch.in_blue = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegEnable;
    cfg_ch.data = '0;
    pixel_sent = 0; drain_sent = 0; settings_run = 0; items_sent = 0;
    cur_w = 1024; cur_h = 768; cur_r = 3; cur_thr = 16'd3891;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: everything bright, saturating scale, drain on an empty block.
    set_config(1'b1, 16'd0, 3'd1, 16'hFFFF, 11'd3, 13'd3);
    send_item(CmdDrain, '0);
    send_item(CmdPixel, '0);
    send_item(CmdPixel, {PXW{1'b1}});
    send_item(CmdPixel, {16'd0, 16'd0, 16'hFFFF});
    send_item(CmdPixel, {16'd0, 16'hFFFF, 16'd0});
    send_item(CmdPixel, {16'hFFFF, 16'd0, 16'd0});
    send_item(CmdPixel, {16'h1000, 16'h1000, 16'h1000});
    send_item(CmdPixel, {16'h0001, 16'h8000, 16'h7FFF});
    send_item(CmdPixel, {16'h5555, 16'hAAAA, 16'h0F0F});
    send_item(CmdPixel, {16'hF0F0, 16'h3333, 16'hCCCC});
    flush_all();
    // Directed: bloom off passes pixels through.
    set_config(1'b0, 16'd3891, 3'd0, 16'd1337, 11'd2, 13'd2);
    send_item(CmdPixel, {PXW{1'b1}});
    send_item(CmdPixel, '0);
    send_item(CmdPixel, {16'h1234, 16'h5678, 16'h9ABC});
    send_item(CmdPixel, {16'hFFFF, 16'h0000, 16'hFFFF});
    flush_all();
    // Directed: top threshold, widest radius on a tiny frame.
    set_config(1'b1, 16'hFFFF, 3'd7, 16'd1337, 11'd4, 13'd2);
    send_item(CmdPixel, {PXW{1'b1}});
    send_item(CmdPixel, {16'hFFFE, 16'hFFFE, 16'hFFFE});
    send_item(CmdPixel, {16'd0, 16'd0, 16'hFFFF});
    send_item(CmdPixel, '0);
    send_item(CmdPixel, {PXW{1'b1}});
    send_item(CmdPixel, {16'h9000, 16'h9000, 16'h9000});
    send_item(CmdPixel, {16'h0000, 16'hFFFF, 16'h0000});
    send_item(CmdPixel, {PXW{1'b1}});
    flush_all();

    // Random settings, sometimes running frames back to back before a flush.
    while (items_sent < 780) begin
      rad = 3'($urandom_range(0, 7));
      w = ($urandom_range(99) < 8) ? 11'd0 : 11'($urandom_range(1, 12));
      h = ($urandom_range(99) < 8) ? 13'd0 : 13'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'($urandom);
        default: thr = 16'($urandom_range(2000, 6000));
      endcase
      case ($urandom_range(0, 3))
        0: rcp = 16'd0;
        1: rcp = 16'hFFFF;
        2: rcp = (rad == 0) ? 16'hFFFF : 16'(65536 / ((2 * rad + 1) * (2 * rad + 1)));
        default: rcp = 16'($urandom);
      endcase
      set_config(1'($urandom_range(99) < 80), thr, rad, rcp, w, h);
      repeat ($urandom_range(1, 3)) random_frame();
      flush_all();
    end

    // Out-of-range sizes clamp to the largest frame; a short stretch of it.
    set_config(1'b1, 16'($urandom), 3'd0, 16'($urandom), 11'h7FF, 13'h1FFF);
    repeat (40) send_item(CmdPixel, pick_pixel());
    flush_all();

    $display("tb: %0d pixels and %0d drains sent over %0d register settings",
             pixel_sent, drain_sent, settings_run);
    $display("tb: %0d results matched, %0d failures", matched, fail_count);
    if (fail_count == 0 && waiting == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== bloom_threshold_box_blur_top.f =====
src/btbb_pkg.sv
src/btbb_if.sv
src/btbb_ctrl.sv
src/btbb_dp.sv
src/bloom_threshold_box_blur_top.sv
test/btbb_checker.sv
test/tb.sv
